[rtl/bzf_pkg.sv]
// Shared types, widths and helpers for the cubic Bezier flattener.
// No dependencies; imported by the controller, the datapath and the top level.
package bzf_pkg;

  localparam int unsigned GUARD = 20;
  localparam int unsigned FW    = 64;   // forward-difference width
  localparam int unsigned MW    = 31;   // saturated magnitude width

  typedef logic signed [FW-1:0] fd_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;       // latch the curve beat
    logic setup;      // polynomial coefficients and flatness squared
    logic init_f;     // initial forward differences
    logic sel_dd;     // 1: doubled-step test, 0: midpoint test
    logic mag_en;     // register distance magnitudes
    logic sq_en;      // register squares
    logic halve;      // halve the step
    logic dbl;        // double the step
    logic adv;        // advance one step and capture the point
    logic push_pend;  // send the held point
    logic push_err;   // send the limit error result
    logic push_end;   // send the end control point (or error at no room)
    logic out_last;   // tlast of the pushed result
  } bzf_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic gt;         // distance above flatness squared
    logic lt;         // distance below flatness squared
    logic out_free;   // output register can take a result
    logic pend_valid; // a point is held
    logic room_zero;  // no room left
  } bzf_sts_t;

  // Signed division by 2^k truncating toward zero
  function automatic fd_t tdiv(input fd_t v, input int unsigned k);
    fd_t bias;
    bias = v[FW-1] ? ((fd_t'(1) <<< k) - fd_t'(1)) : fd_t'(0);
    return (v + bias) >>> k;
  endfunction

  // Magnitude dropped to Q16.16 and saturated to 31 bits
  function automatic logic [MW-1:0] mag_q16(input fd_t v);
    logic [FW:0] m;
    logic [FW:0] s;
    m = v[FW-1] ? ((FW+1)'(0) - {v[FW-1], v}) : {1'b0, v};
    s = m >> GUARD;
    return (s > (FW+1)'(32'h7FFF_FFFF)) ? MW'(32'h7FFF_FFFF) : s[MW-1:0];
  endfunction

  // Round half up to Q16.16 and saturate to 32 bits
  function automatic logic [31:0] to_q16(input fd_t v);
    logic signed [FW:0] r;
    r = ($signed({v[FW-1], v}) + (FW+1)'(1 << (GUARD - 1))) >>> GUARD;
    if (r > $signed((FW+1)'(32'h7FFF_FFFF))) return 32'h7FFF_FFFF;
    if (r < -$signed((FW+1)'(33'h0_8000_0000))) return 32'h8000_0000;
    return r[31:0];
  endfunction

endpackage

[rtl/bzf_datapath.sv]
// Datapath of the flattener: forward differences, distance tests, held point
// and output register. Depends on bzf_pkg; driven by bzf_ctrl commands.
module bzf_datapath
  import bzf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  bzf_cmd_t       cmd,
  output bzf_sts_t       sts,
  input  logic [271:0]   in_tdata,
  input  logic [23:0]    flatness,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);

  logic signed [31:0] pt_r [8];
  logic [15:0]        room_r;
  fd_t                a_r [2], b_r [2], c_r [2];
  fd_t                f0_r [2], f1_r [2], f2_r [2], f3_r [2];
  logic [47:0]        flat2_r;
  logic [MW-1:0]      mag_r [2];
  logic [2*MW-1:0]    sq_r [2];
  logic [31:0]        pend_x_r, pend_y_r;
  logic               pend_valid_r;
  logic               out_valid_r;
  logic [31:0]        ox_r, oy_r;
  logic               ohp_r, ost_r, olast_r;
  logic [2*MW:0]      dsum;
  logic               push;

  // Latch the curve
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) pt_r[i] <= $signed(in_tdata[32*i +: 32]);
    end
  end

  // Room count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      room_r <= in_tdata[271:256];
    end else if (cmd.adv) begin
      room_r <= room_r - 16'd1;
    end
  end

  // Coefficients, flatness squared, forward differences
  always_ff @(posedge clk) begin
    fd_t s, p1, p2, p3, t, a6, b2, f3h, f2h;
    if (cmd.setup) begin
      flat2_r <= 48'(flatness) * 48'(flatness);
      for (int d = 0; d < 2; d++) begin
        s  = fd_t'(pt_r[d]);
        p1 = fd_t'(pt_r[2+d]);
        p2 = fd_t'(pt_r[4+d]);
        p3 = fd_t'(pt_r[6+d]);
        t  = p1 - p2;
        a_r[d] <= (p3 - s + (t <<< 1) + t) <<< GUARD;
        t  = s - (p1 <<< 1) + p2;
        b_r[d] <= ((t <<< 1) + t) <<< GUARD;
        t  = p1 - s;
        c_r[d] <= ((t <<< 1) + t) <<< GUARD;
      end
    end
    for (int d = 0; d < 2; d++) begin
      a6 = (a_r[d] <<< 2) + (a_r[d] <<< 1);
      b2 = b_r[d] <<< 1;
      if (cmd.init_f) begin
        f0_r[d] <= fd_t'(pt_r[d]) <<< GUARD;
        f1_r[d] <= tdiv(a_r[d], 6) + tdiv(b_r[d], 4) + tdiv(c_r[d], 2);
        f2_r[d] <= tdiv(a6, 6) + tdiv(b2, 4);
        f3_r[d] <= tdiv(a6, 6);
      end else if (cmd.halve) begin
        f3h = tdiv(f3_r[d], 3);
        f2h = tdiv(f2_r[d], 2) - f3h;
        f3_r[d] <= f3h;
        f2_r[d] <= f2h;
        f1_r[d] <= tdiv(f1_r[d] - f2h, 1);
      end else if (cmd.dbl) begin
        f1_r[d] <= (f1_r[d] <<< 1) + f2_r[d];
        f2_r[d] <= (f2_r[d] + f3_r[d]) <<< 2;
        f3_r[d] <= f3_r[d] <<< 3;
      end else if (cmd.adv) begin
        f0_r[d] <= f0_r[d] + f1_r[d];
        f1_r[d] <= f1_r[d] + f2_r[d];
        f2_r[d] <= f2_r[d] + f3_r[d];
      end
    end
  end

  // Distance magnitudes, then squares
  always_ff @(posedge clk) begin
    for (int d = 0; d < 2; d++) begin
      if (cmd.mag_en) begin
        mag_r[d] <= cmd.sel_dd ? mag_q16(tdiv(f2_r[d], 1))
                               : mag_q16(tdiv(f2_r[d], 3) - tdiv(f3_r[d], 4));
      end
      if (cmd.sq_en) sq_r[d] <= (2*MW)'(mag_r[d]) * (2*MW)'(mag_r[d]);
    end
  end

  assign dsum = (2*MW+1)'(sq_r[0]) + (2*MW+1)'(sq_r[1]);

  // Held point: the newest end point, sent once the next step is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.adv) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.push_pend) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      pend_x_r <= to_q16(f0_r[0] + f1_r[0]);
      pend_y_r <= to_q16(f0_r[1] + f1_r[1]);
    end
  end

  // Output register
  assign push = cmd.push_pend | cmd.push_err | cmd.push_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    olast_r <= push ? cmd.out_last : olast_r;
    if (cmd.push_pend) begin
      ox_r <= pend_x_r;
      oy_r <= pend_y_r;
      ohp_r <= 1'b1;
      ost_r <= 1'b0;
    end else if (cmd.push_err || (cmd.push_end && room_r == 16'd0)) begin
      ox_r <= 32'd0;
      oy_r <= 32'd0;
      ohp_r <= 1'b0;
      ost_r <= 1'b1;
    end else if (cmd.push_end) begin
      ox_r <= pt_r[6];
      oy_r <= pt_r[7];
      ohp_r <= 1'b1;
      ost_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tuser  = {ost_r, ohp_r};
  assign out_tlast  = olast_r;

  assign sts.gt         = dsum > (2*MW+1)'(flat2_r);
  assign sts.lt         = dsum < (2*MW+1)'(flat2_r);
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.pend_valid = pend_valid_r;
  assign sts.room_zero  = room_r == 16'd0;

endmodule

[rtl/bzf_ctrl.sv]
// Controller of the flattener: step size, segment index and result sequencing.
// Depends on bzf_pkg; issues commands to bzf_datapath.
module bzf_ctrl
  import bzf_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bzf_sts_t sts,
  output bzf_cmd_t cmd
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1) + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SETUP1 = 9'b000000010,
    S_SETUP2 = 9'b000000100,
    S_MAG    = 9'b000001000,
    S_SQ     = 9'b000010000,
    S_CMP    = 9'b000100000,
    S_ADV    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_ERR    = 9'b100000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  loop_r, loop_nxt, maxs_r, maxs_nxt;
  logic           dd_r, dd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loop_r  <= '0;
      maxs_r  <= CW'(4);
      dd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
      maxs_r  <= maxs_nxt;
      dd_r    <= dd_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Sequence decisions over the walk
  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    maxs_nxt  = maxs_r;
    dd_nxt    = dd_r;
    cmd       = '0;
    cmd.sel_dd = dd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          loop_nxt  = '0;
          maxs_nxt  = CW'(4);
          dd_nxt    = 1'b0;
          state_nxt = S_SETUP1;
        end
      end
      S_SETUP1: begin
        cmd.setup = 1'b1;
        state_nxt = S_SETUP2;
      end
      S_SETUP2: begin
        cmd.init_f = 1'b1;
        state_nxt  = S_MAG;
      end
      S_MAG: begin
        cmd.mag_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!dd_r) begin
          if (sts.gt) begin
            if ((maxs_r << 1) <= CW'(MAX_SEGMENTS)) begin
              cmd.halve = 1'b1;
              maxs_nxt  = maxs_r << 1;
              loop_nxt  = loop_r << 1;
              state_nxt = S_MAG;
            end else begin
              state_nxt = S_ADV;
            end
          end else if (!loop_r[0]) begin
            dd_nxt    = 1'b1;
            state_nxt = S_MAG;
          end else begin
            state_nxt = S_ADV;
          end
        end else begin
          dd_nxt = 1'b0;
          if (sts.lt) begin
            if (maxs_r == CW'(1)) begin
              state_nxt = S_FIN;
            end else begin
              cmd.dbl   = 1'b1;
              maxs_nxt  = maxs_r >> 1;
              loop_nxt  = loop_r >> 1;
              state_nxt = S_MAG;
            end
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (sts.room_zero) begin
          state_nxt = S_ERR;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.adv       = 1'b1;
          cmd.push_pend = sts.pend_valid;
          loop_nxt      = loop_r + CW'(1);
          state_nxt     = (loop_r + CW'(1) >= maxs_r) ? S_FIN : S_MAG;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_last  = 1'b1;
          cmd.push_pend = sts.pend_valid;
          cmd.push_end  = !sts.pend_valid;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.push_pend = 1'b1;
          end else begin
            cmd.push_err  = 1'b1;
            cmd.out_last  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/bezier_adaptive_flattener_top.sv]
// Cubic Bezier flattener by adaptive forward differencing; needs bzf_pkg, bzf_ctrl, bzf_datapath.
// Each curve is loaded and set up (coefficients, then initial differences); each step runs a
// flatness test (magnitudes, squares, compare), at an even index a doubled-step test too, halves
// or doubles the step as the tests decide, then advances; a closing state sends the last result
// and output stalls hold the walk. One curve at a time: the next beat is taken only when idle.
// Reset (rst_n low, synchronous) returns to idle and sets flatness to 1.0.
module bezier_adaptive_flattener_top
  import bzf_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data,    // flatness
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, room_left
  input  logic [271:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // seg_x, seg_y
  output logic [1:0]   out_tuser,   // has_point, status
  output logic         out_tlast    // last
);

  logic [23:0] flatness_r;
  bzf_cmd_t    cmd;
  bzf_sts_t    sts;

  // Hold the flatness register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flatness_r <= 24'd65536;
    end else if (cfg_valid) begin
      flatness_r <= cfg_data;
    end
  end

  bzf_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bzf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .flatness   (flatness_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
